/* rtl/wcq_pkg.sv */
// Shared types, constants and helper functions of the waterfall column quantizer.
// No dependencies; the front, lane, merge and top files import this package.
package wcq_pkg;

  localparam int WINDOW_LEN_DEF = 8;
  localparam int ROWS_DEF       = 256;
  localparam int MAX_BINS_DEF   = 2048;

  localparam int FIRST_PICK = 10;
  localparam int COL_LIMIT  = 4096;
  localparam int LEVEL_MIN  = 1;
  localparam int LEVEL_MAX  = 64;
  localparam int DB_SCALE   = 394566;  // round(65536 * 20 * log10(2))
  localparam int ROUND_HALF = 32768;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int LANE_DEPTH = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN      = 2'd0,
    CFG_OFFSET    = 2'd1,
    CFG_DEC_STEP  = 2'd2,
    CFG_COL_COUNT = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] gain;
    logic signed [15:0] offset;
    logic [12:0]        dec_step;
    logic [12:0]        col_count;
  } cfg_t;

  typedef struct packed {
    logic [31:0] sample_a;
    logic [31:0] sample_b;
    logic        last_bin;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  level_a;
    logic [6:0]  level_b;
    logic [11:0] column;
    logic [7:0]  row;
    logic        last_column;
  } out_item_t;

  // position info that travels alongside the lanes
  typedef struct packed {
    logic [11:0] column;
    logic [7:0]  row;
    logic        last_column;
  } side_t;

  function automatic int sum_width(input int window_len);
    return 32 + $clog2(window_len);
  endfunction

  // width of the scaled level word at the end of a lane
  function automatic int lane_v_width(input int sum_w);
    return $clog2(sum_w) + 30;
  endfunction

  // round(256 * log2(1 + k/16)), k = 0..16
  function automatic logic [8:0] log_tab(input logic [4:0] k);
    logic [8:0] t;
    case (k)
      5'd0:    t = 9'd0;
      5'd1:    t = 9'd22;
      5'd2:    t = 9'd44;
      5'd3:    t = 9'd63;
      5'd4:    t = 9'd82;
      5'd5:    t = 9'd100;
      5'd6:    t = 9'd118;
      5'd7:    t = 9'd134;
      5'd8:    t = 9'd150;
      5'd9:    t = 9'd165;
      5'd10:   t = 9'd179;
      5'd11:   t = 9'd193;
      5'd12:   t = 9'd207;
      5'd13:   t = 9'd220;
      5'd14:   t = 9'd232;
      5'd15:   t = 9'd244;
      default: t = 9'd256;
    endcase
    return t;
  endfunction

endpackage

/* rtl/wcq_if.sv */
// Valid/ready channel carrying one item of a given payload type.
// Depends on nothing; payload types come from wcq_pkg at instantiation.
interface wcq_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/wcq_front.sv */
// Front end: boxcar delay lines and running sums, bin/column/row counters
// and the column pick decision. Uses wcq_pkg.
module wcq_front import wcq_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF,
  parameter int ROWS       = ROWS_DEF,
  parameter int MAX_BINS   = MAX_BINS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_fire,
  input  in_item_t                           in_data,
  input  cfg_t                               cfg,
  output logic                               vld,
  output side_t                              side,
  output logic [sum_width(WINDOW_LEN)-1:0]   sum_a,
  output logic [sum_width(WINDOW_LEN)-1:0]   sum_b
);

  localparam int SUM_W = sum_width(WINDOW_LEN);
  localparam int BC_W  = $clog2(MAX_BINS + 1);
  localparam int NP_W  = $clog2(MAX_BINS + COL_LIMIT);
  localparam int RP_W  = $clog2(ROWS);

  logic [31:0]      win_a_r [WINDOW_LEN];
  logic [31:0]      win_b_r [WINDOW_LEN];
  logic [SUM_W-1:0] sum_a_r, sum_b_r, sum_a_nxt, sum_b_nxt;
  logic [BC_W-1:0]  bin_count_r;
  logic [NP_W-1:0]  next_pick_r;
  logic [12:0]      col_idx_r;
  logic [RP_W-1:0]  row_ptr_r;

  logic             vld_r;
  side_t            side_r;
  logic [SUM_W-1:0] snap_a_r, snap_b_r;

  logic [12:0]      cols, step;
  logic             pick;
  logic [RP_W+7:0]  row_ext;

  always_comb begin
    cols = (cfg.col_count > 13'(COL_LIMIT)) ? 13'(COL_LIMIT) : cfg.col_count;
    step = (cfg.dec_step == 13'd0) ? 13'd1 : cfg.dec_step;
    sum_a_nxt = sum_a_r + SUM_W'(in_data.sample_a) - SUM_W'(win_a_r[WINDOW_LEN-1]);
    sum_b_nxt = sum_b_r + SUM_W'(in_data.sample_b) - SUM_W'(win_b_r[WINDOW_LEN-1]);
    pick = (bin_count_r < BC_W'(MAX_BINS)) && (NP_W'(bin_count_r) == next_pick_r) &&
           (col_idx_r < cols);
    row_ext = {8'd0, row_ptr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_a_r[i] <= '0;
        win_b_r[i] <= '0;
      end
      sum_a_r     <= '0;
      sum_b_r     <= '0;
      bin_count_r <= '0;
      next_pick_r <= NP_W'(FIRST_PICK);
      col_idx_r   <= '0;
      row_ptr_r   <= RP_W'(ROWS - 1);
      vld_r       <= 1'b0;
    end else begin
      if (en) begin
        vld_r <= in_fire && pick;
      end
      if (in_fire) begin
        if (in_data.last_bin) begin
          for (int i = 0; i < WINDOW_LEN; i++) begin
            win_a_r[i] <= '0;
            win_b_r[i] <= '0;
          end
          sum_a_r     <= '0;
          sum_b_r     <= '0;
          bin_count_r <= '0;
          next_pick_r <= NP_W'(FIRST_PICK);
          col_idx_r   <= '0;
          row_ptr_r   <= (row_ptr_r == '0) ? RP_W'(ROWS - 1) : row_ptr_r - 1'b1;
        end else begin
          for (int i = WINDOW_LEN - 1; i > 0; i--) begin
            win_a_r[i] <= win_a_r[i-1];
            win_b_r[i] <= win_b_r[i-1];
          end
          win_a_r[0] <= in_data.sample_a;
          win_b_r[0] <= in_data.sample_b;
          sum_a_r    <= sum_a_nxt;
          sum_b_r    <= sum_b_nxt;
          if (bin_count_r < BC_W'(MAX_BINS)) begin
            bin_count_r <= bin_count_r + 1'b1;
          end
          if (pick) begin
            col_idx_r   <= col_idx_r + 13'd1;
            next_pick_r <= next_pick_r + NP_W'(step);
          end
        end
      end
    end
  end

  // snapshot of each accepted bin, held while the lanes stall
  always_ff @(posedge clk) begin
    if (in_fire) begin
      snap_a_r           <= sum_a_nxt;
      snap_b_r           <= sum_b_nxt;
      side_r.column      <= col_idx_r[11:0];
      side_r.row         <= row_ext[7:0];
      side_r.last_column <= (col_idx_r == cols - 13'd1);
    end
  end

  assign vld   = vld_r;
  assign side  = side_r;
  assign sum_a = snap_a_r;
  assign sum_b = snap_b_r;

endmodule

/* rtl/wcq_lane.sv */
// One channel lane: leading-one search, table log2, dB scaling and gain/offset,
// five register stages, each advanced by its own enable. Uses wcq_pkg.
module wcq_lane import wcq_pkg::*; #(
  parameter int SUM_W = sum_width(WINDOW_LEN_DEF)
) (
  input  logic                                  clk,
  input  logic [LANE_DEPTH-1:0]                 adv,
  input  logic signed [15:0]                    gain,
  input  logic signed [15:0]                    offset,
  input  logic [SUM_W-1:0]                      sum_in,
  output logic                                  zero,
  output logic signed [lane_v_width(SUM_W)-1:0] v
);

  localparam int E_W  = $clog2(SUM_W);
  localparam int L_W  = E_W + 9;
  localparam int P_W  = L_W + 19;
  localparam int DB_W = L_W + 3;
  localparam int V_W  = lane_v_width(SUM_W);

  logic [E_W-1:0]       lead;
  logic [SUM_W+11:0]    ext;
  logic [8:0]           t0, t1;
  logic [4:0]           dlt;
  logic [13:0]          interp_raw;
  logic [L_W-1:0]       l_nxt;
  logic [P_W-1:0]       prod_db;
  logic signed [16+DB_W:0] prod_v;
  logic signed [V_W-1:0]   v_nxt;

  logic [SUM_W-1:0]     s1_sum_r;
  logic [E_W-1:0]       s1_e_r, s2_e_r;
  logic                 s1_zero_r, s2_zero_r, s3_zero_r, s4_zero_r, s5_zero_r;
  logic [3:0]           s2_k_r;
  logic [7:0]           s2_f_r;
  logic [L_W-1:0]       s3_l_r;
  logic [DB_W-1:0]      s4_db_r;
  logic signed [V_W-1:0] s5_v_r;

  always_comb begin
    lead = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (sum_in[i]) lead = E_W'(i);
    end
    // 12 bits below the leading one, zero-filled under bit 0
    ext = {s1_sum_r, 12'd0} >> s1_e_r;
    t0 = log_tab({1'b0, s2_k_r});
    t1 = log_tab({1'b0, s2_k_r} + 5'd1);
    dlt = 5'(t1 - t0);
    interp_raw = 14'(dlt) * 14'(s2_f_r) + 14'd128;
    l_nxt = L_W'({s2_e_r, 8'd0}) + L_W'(t0) + L_W'(interp_raw[13:8]);
    prod_db = s3_l_r * P_W'(DB_SCALE) + P_W'(ROUND_HALF);
    prod_v = gain * $signed({1'b0, s4_db_r});
    v_nxt = V_W'(prod_v) + (V_W'(offset) <<< 8) + V_W'(ROUND_HALF);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_sum_r  <= sum_in;
      s1_e_r    <= lead;
      s1_zero_r <= (sum_in == '0);
    end
    if (adv[1]) begin
      s2_k_r    <= ext[11:8];
      s2_f_r    <= ext[7:0];
      s2_e_r    <= s1_e_r;
      s2_zero_r <= s1_zero_r;
    end
    if (adv[2]) begin
      s3_l_r    <= l_nxt;
      s3_zero_r <= s2_zero_r;
    end
    if (adv[3]) begin
      s4_db_r   <= prod_db[P_W-1:16];
      s4_zero_r <= s3_zero_r;
    end
    if (adv[4]) begin
      s5_v_r    <= v_nxt;
      s5_zero_r <= s4_zero_r;
    end
  end

  assign zero = s5_zero_r;
  assign v    = s5_v_r;

endmodule

/* rtl/wcq_merge.sv */
// Merge stage: clamps both lane results to levels, joins them with the column
// and row info and holds the item in the output register. Uses wcq_pkg.
module wcq_merge import wcq_pkg::*; #(
  parameter int SUM_W = sum_width(WINDOW_LEN_DEF)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  vld_in,
  input  side_t                                 side,
  input  logic                                  zero_a,
  input  logic                                  zero_b,
  input  logic signed [lane_v_width(SUM_W)-1:0] v_a,
  input  logic signed [lane_v_width(SUM_W)-1:0] v_b,
  input  logic                                  out_ready,
  output logic                                  en,
  output logic                                  out_valid,
  output out_item_t                             out_data
);

  localparam int V_W = lane_v_width(SUM_W);

  logic      out_valid_r;
  out_item_t out_data_r;

  function automatic logic [6:0] clamp_level(input logic zero_in,
                                             input logic signed [V_W-1:0] val);
    logic [6:0] lvl;
    if (zero_in || (val < $signed(V_W'(65536)))) begin
      lvl = 7'(LEVEL_MIN);
    end else if (val >= $signed(V_W'(LEVEL_MAX * 65536))) begin
      lvl = 7'(LEVEL_MAX);
    end else begin
      lvl = val[22:16];
    end
    return lvl;
  endfunction

  assign en = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.level_a     <= clamp_level(zero_a, v_a);
      out_data_r.level_b     <= clamp_level(zero_b, v_b);
      out_data_r.column      <= side.column;
      out_data_r.row         <= side.row;
      out_data_r.last_column <= side.last_column;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/waterfall_column_quantizer.sv */
// Waterfall column quantizer, top level.
// Depends on wcq_pkg, wcq_if, wcq_front, wcq_lane and wcq_merge.
//
// Usage: spectrum bins arrive on in_ch (sample_a, sample_b, last_bin), one item
// per bin. Each bin updates a WINDOW_LEN boxcar sum per channel; at the picked
// bins (10, 10+dec_step, ...) while fewer than col_count columns are out, one
// item with both dB levels (1..64), column, row and last_column goes out on
// out_ch. Other bins produce nothing. last_bin clears the sums and counters and
// steps the row pointer down, wrapping to ROWS-1.
// Throughput: one bin per clock while out_ch.ready does not stall the pipeline. A
// picked bin's result passes the front register, five lane stages and the output
// register on its way to out_ch; the two channel lanes run side by side.
// Configuration: cfg_we/cfg_index/cfg_data write gain, offset, dec_step and
// col_count; write only while no item is in flight.
// Reset (rst_n low, synchronous): config returns to defaults, delay lines,
// sums and counters clear, row pointer goes to ROWS-1; no clearing pass.
// Stall: when out_ch.ready is low, empty pipeline stages still fill; in_ch.ready
// drops only once the front register and every stage behind it hold items.
module waterfall_column_quantizer import wcq_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF,
  parameter int ROWS       = ROWS_DEF,
  parameter int MAX_BINS   = MAX_BINS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  wcq_if.sink                   in_ch,
  wcq_if.source                 out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SUM_W = sum_width(WINDOW_LEN);
  localparam int V_W   = lane_v_width(SUM_W);

  cfg_t                  cfg_r;
  logic                  en_front, in_fire, front_vld;
  side_t                 front_side;
  logic [SUM_W-1:0]      front_sum_a, front_sum_b;
  logic [LANE_DEPTH-1:0] en_lane, vld_r;
  side_t                 side_r [LANE_DEPTH];
  logic                  en_out, zero_a, zero_b;
  logic signed [V_W-1:0] v_a, v_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain      <= 16'sd256;
      cfg_r.offset    <= 16'sd0;
      cfg_r.dec_step  <= 13'd1;
      cfg_r.col_count <= 13'd256;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GAIN:      cfg_r.gain      <= cfg_data;
        CFG_OFFSET:    cfg_r.offset    <= cfg_data;
        CFG_DEC_STEP:  cfg_r.dec_step  <= cfg_data[12:0];
        CFG_COL_COUNT: cfg_r.col_count <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // a stage may load when it is empty or its successor loads
  always_comb begin
    en_lane[LANE_DEPTH-1] = !vld_r[LANE_DEPTH-1] || en_out;
    for (int i = LANE_DEPTH - 2; i >= 0; i--) begin
      en_lane[i] = !vld_r[i] || en_lane[i+1];
    end
    en_front = !front_vld || en_lane[0];
  end

  assign in_ch.ready = en_front;
  assign in_fire     = in_ch.valid && en_front;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en_lane[0]) vld_r[0] <= front_vld;
      for (int i = 1; i < LANE_DEPTH; i++) begin
        if (en_lane[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_lane[0]) side_r[0] <= front_side;
    for (int i = 1; i < LANE_DEPTH; i++) begin
      if (en_lane[i]) side_r[i] <= side_r[i-1];
    end
  end

  wcq_front #(
    .WINDOW_LEN (WINDOW_LEN),
    .ROWS       (ROWS),
    .MAX_BINS   (MAX_BINS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en_front),
    .in_fire (in_fire),
    .in_data (in_ch.data),
    .cfg     (cfg_r),
    .vld     (front_vld),
    .side    (front_side),
    .sum_a   (front_sum_a),
    .sum_b   (front_sum_b)
  );

  wcq_lane #(.SUM_W(SUM_W)) u_lane_a (
    .clk    (clk),
    .adv    (en_lane),
    .gain   (cfg_r.gain),
    .offset (cfg_r.offset),
    .sum_in (front_sum_a),
    .zero   (zero_a),
    .v      (v_a)
  );

  wcq_lane #(.SUM_W(SUM_W)) u_lane_b (
    .clk    (clk),
    .adv    (en_lane),
    .gain   (cfg_r.gain),
    .offset (cfg_r.offset),
    .sum_in (front_sum_b),
    .zero   (zero_b),
    .v      (v_b)
  );

  wcq_merge #(.SUM_W(SUM_W)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld_in    (vld_r[LANE_DEPTH-1]),
    .side      (side_r[LANE_DEPTH-1]),
    .zero_a    (zero_a),
    .zero_b    (zero_b),
    .v_a       (v_a),
    .v_b       (v_b),
    .out_ready (out_ch.ready),
    .en        (en_out),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.data)
  );

`ifndef SYNTHESIS
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.data.level_a >= 7'd1) && (out_ch.data.level_a <= 7'd64) &&
                     (out_ch.data.level_b >= 7'd1) && (out_ch.data.level_b <= 7'd64))
    else $error("level out of range");

  a_last_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[LANE_DEPTH-1] && !en_lane[LANE_DEPTH-1]) |=> vld_r[LANE_DEPTH-1])
    else $error("stalled item dropped from last lane stage");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (front_vld && vld_r[0] && out_ch.valid))
    else $error("input stalled with an empty pipeline stage");
`endif

endmodule
